// ===== src/ookms_pkg.sv =====
package ookms_pkg;

  // sequencer steps, also the address of the control store
  typedef enum logic [2:0] {
    STEP_IDLE = 3'd0,
    STEP_HDR  = 3'd1,
    STEP_SEQ  = 3'd2,
    STEP_BYTE = 3'd3,
    STEP_STOP = 3'd4
  } step_t;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_WAIT     = 3'd0,
    OP_HDR      = 3'd1,
    OP_MAN_SEQ  = 3'd2,
    OP_MAN_BYTE = 3'd3,
    OP_STOP     = 3'd4
  } op_t;

  // condition under which a step runs, else it is skipped
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_FIRST  = 2'd1,
    COND_VALID  = 2'd2,
    COND_LAST   = 2'd3
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t nxt;
  } ucode_t;

  // configuration register indexes
  localparam logic [1:0] REG_HEADER_PATTERN = 2'd0;
  localparam logic [1:0] REG_HEADER_LENGTH  = 2'd1;

  localparam logic [4:0] MAN_CHIPS  = 5'd16;
  localparam logic [4:0] STOP_CHIPS = 5'd2;

  // control store
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      STEP_IDLE: w = '{op: OP_WAIT,     cond: COND_ALWAYS, nxt: STEP_HDR};
      STEP_HDR:  w = '{op: OP_HDR,      cond: COND_FIRST,  nxt: STEP_SEQ};
      STEP_SEQ:  w = '{op: OP_MAN_SEQ,  cond: COND_FIRST,  nxt: STEP_BYTE};
      STEP_BYTE: w = '{op: OP_MAN_BYTE, cond: COND_VALID,  nxt: STEP_STOP};
      STEP_STOP: w = '{op: OP_STOP,     cond: COND_LAST,   nxt: STEP_IDLE};
      default:   w = '{op: OP_WAIT,     cond: COND_ALWAYS, nxt: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/ook_manchester_frame_serializer_top.sv =====
// on-off-keyed light link frame serializer with manchester coding
//
// input stream: one transaction per payload item. tdata carries the payload
// byte and the frame sequence byte, tuser the byte-valid and first-item flags,
// tlast the last-item flag. the item is held while its chips are produced and
// in_tready is high only between items.
// output stream: one transaction per line chip, tdata bit 0 is the light
// level, tlast marks the final chip caused by the item.
// a first item sends header_length raw header chips (capped at
// MAX_HEADER_CHIPS) then 16 sequence chips; a valid byte adds 16 chips and a
// last item two low stop chips.
// a small control store steps through wait, header, sequence, byte and stop;
// a running step puts out one chip per cycle unless the receiver stalls, and a
// step whose condition does not hold for the item, or that has no chips, is
// skipped. the sequencer takes no new item until it is back in the wait step.
// when the receiver stalls, the output register holds its chip and the
// sequencer waits; no chip is dropped.
// reset (synchronous, active low) returns the sequencer to wait, empties the
// output register and clears both configuration registers.
// configuration is written through cfg_we/cfg_addr/cfg_wdata between items.
module ook_manchester_frame_serializer_top
  import ookms_pkg::*;
#(
  parameter int MAX_HEADER_CHIPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // input item stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] payload_byte, [15:8] frame_seq
  input  logic [1:0]  in_tuser,   // [0] byte_valid, [1] first_item
  input  logic        in_tlast,   // last_item
  // chip stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] line_level, [7:1] zero
  output logic        out_tlast   // last_chip
);

  localparam logic [4:0] MAX_HDR = 5'(MAX_HEADER_CHIPS);

  // configuration registers
  logic [15:0] header_pattern_r;
  logic [4:0]  header_length_r;

  // latched item
  logic [7:0] payload_byte_r;
  logic [7:0] frame_seq_r;
  logic       byte_valid_r;
  logic       first_item_r;
  logic       last_item_r;

  // sequencer
  step_t      pc_r, pc_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  // output register
  logic out_tvalid_r;
  logic out_level_r;
  logic out_last_r;

  ucode_t     uw;
  logic       cond_ok;
  logic [4:0] limit;
  logic [4:0] len_eff;
  logic       can_emit;
  logic       emit;
  logic       chip_level;
  logic       chip_last;
  logic       step_end;
  op_t        final_op;
  logic [7:0] man_byte;
  logic       man_bit;
  logic [3:0] hdr_pos;
  logic       in_accept;

  assign len_eff   = (header_length_r > MAX_HDR) ? MAX_HDR : header_length_r;
  assign uw        = ucode_rom(pc_r);
  assign can_emit  = !out_tvalid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (pc_r == STEP_IDLE);

  // the step whose last chip closes the item
  always_comb begin
    priority if (last_item_r) final_op = OP_STOP;
    else if (byte_valid_r)    final_op = OP_MAN_BYTE;
    else                      final_op = OP_MAN_SEQ;
  end

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS: cond_ok = 1'b1;
      COND_FIRST:  cond_ok = first_item_r;
      COND_VALID:  cond_ok = byte_valid_r;
      COND_LAST:   cond_ok = last_item_r;
      default:     cond_ok = 1'b0;
    endcase
  end

  // chip datapath
  assign man_byte   = (uw.op == OP_MAN_SEQ) ? frame_seq_r : payload_byte_r;
  assign man_bit    = man_byte[3'd7 - cnt_r[3:1]];
  assign hdr_pos    = 4'(len_eff - 5'd1 - {1'b0, cnt_r});

  always_comb begin
    limit      = 5'd0;
    chip_level = 1'b0;
    unique case (uw.op)
      OP_WAIT: begin
        limit      = 5'd0;
        chip_level = 1'b0;
      end
      OP_HDR: begin
        limit      = len_eff;
        chip_level = header_pattern_r[hdr_pos];
      end
      OP_MAN_SEQ, OP_MAN_BYTE: begin
        limit      = MAN_CHIPS;
        // a one is low then high, a zero high then low
        chip_level = cnt_r[0] ? man_bit : ~man_bit;
      end
      OP_STOP: begin
        limit      = STOP_CHIPS;
        chip_level = 1'b0;
      end
      default: begin
        limit      = 5'd0;
        chip_level = 1'b0;
      end
    endcase
  end

  assign step_end  = (({1'b0, cnt_r} + 5'd1) == limit);
  assign chip_last = step_end && (uw.op == final_op);

  // sequencer next state
  always_comb begin
    pc_nxt  = pc_r;
    cnt_nxt = cnt_r;
    emit    = 1'b0;
    if (uw.op == OP_WAIT) begin
      if (in_accept) begin
        pc_nxt  = uw.nxt;
        cnt_nxt = '0;
      end
    end else if (!cond_ok || limit == 5'd0) begin
      // step not taken for this item
      pc_nxt  = uw.nxt;
      cnt_nxt = '0;
    end else if (can_emit) begin
      emit = 1'b1;
      if (step_end) begin
        pc_nxt  = uw.nxt;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= STEP_IDLE;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_pattern_r <= '0;
      header_length_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_HEADER_PATTERN) header_pattern_r <= cfg_wdata;
      if (cfg_addr == REG_HEADER_LENGTH)  header_length_r  <= cfg_wdata[4:0];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      payload_byte_r <= in_tdata[7:0];
      frame_seq_r    <= in_tdata[15:8];
      byte_valid_r   <= in_tuser[0];
      first_item_r   <= in_tuser[1];
      last_item_r    <= in_tlast;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_level_r <= chip_level;
      out_last_r  <= chip_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_level_r};
  assign out_tlast  = out_last_r;

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (pc_r == STEP_HDR && cnt_r == 4'd0))
    else $error("accepted item did not start the header step");

  // the sequencer still passes through any skipped steps after the final chip
  a_final_chip_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && chip_last) |-> ##[1:3] (pc_r == STEP_IDLE))
    else $error("sequencer kept running after the final chip");

  a_hdr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && uw.op == OP_HDR) |-> ({1'b0, cnt_r} < len_eff))
    else $error("header chip index beyond header length");

  a_no_emit_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !emit)
    else $error("chip produced while output register is stalled");

endmodule

// ===== tb/ook_manchester_frame_serializer_top_tb.sv =====
module ook_manchester_frame_serializer_top_tb;
  import ookms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // indexes past the two real registers, writes there must not change anything
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  // random phases and the number of items counted in each, loose chip-less items apart
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 54;

  // cycles to let pass once nothing is expected: covers an item with no chips
  localparam int SETTLE_CYCLES = 64;

  // slowest run: ~500 items x 50 chips, longest stall each, plus gaps and pauses
  localparam int CYCLE_LIMIT = 3_000_000;

  // one payload item as the block sees it
  typedef struct {
    logic [7:0] payload;
    logic       valid;
    logic [7:0] seq;
    logic       first;
    logic       last;
  } frame_item_t;

  // predicts the chip stream and holds the chips still owed by the block
  class chip_tracker;
    typedef struct {
      logic level;
      logic last;
    } chip_t;

    logic [15:0] hdr_pattern;
    logic [4:0]  hdr_len;
    chip_t       chips_due[$];
    int          errors;

    function new();
      hdr_pattern = '0;
      hdr_len     = '0;
      errors      = 0;
    endfunction

    // unknown indexes fall through and leave both registers alone
    function void set_reg(logic [1:0] addr, logic [15:0] data);
      if (addr == REG_HEADER_PATTERN) hdr_pattern = data;
      else if (addr == REG_HEADER_LENGTH) hdr_len = data[4:0];
    endfunction

    function void push_chip(logic level);
      chip_t c;
      c.level = level;
      c.last  = 1'b0;
      chips_due.push_back(c);
    endfunction

    // msb first, a one is low then high, a zero is high then low
    function void push_manchester(logic [7:0] b);
      for (int i = 7; i >= 0; i--) begin
        push_chip(~b[i]);
        push_chip(b[i]);
      end
    endfunction

    function void note_item(frame_item_t it);
      int prev_size;
      int len;
      prev_size = chips_due.size();
      if (it.first) begin
        // lengths above the header store are capped
        len = (hdr_len > 5'd16) ? 16 : int'(hdr_len);
        for (int i = 0; i < len; i++) push_chip(hdr_pattern[len - 1 - i]);
        push_manchester(it.seq);
      end
      if (it.valid) push_manchester(it.payload);
      if (it.last) begin
        push_chip(1'b0);
        push_chip(1'b0);
      end
      if (chips_due.size() > prev_size) chips_due[chips_due.size() - 1].last = 1'b1;
    endfunction

    function void check_chip(logic [7:0] tdata, logic tlast);
      chip_t want;
      if (chips_due.size() == 0) begin
        $display("%0t: unexpected chip, expected none, got tdata %h last %b",
                 $time, tdata, tlast);
        errors++;
        return;
      end
      want = chips_due.pop_front();
      if (tdata !== {7'b0, want.level}) begin
        $display("%0t: chip level mismatch, expected tdata %h, got %h",
                 $time, {7'b0, want.level}, tdata);
        errors++;
      end
      if (tlast !== want.last) begin
        $display("%0t: chip last mismatch, expected %b, got %b",
                 $time, want.last, tlast);
        errors++;
      end
    endfunction

    function int pending();
      return chips_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  // idling switches, turned on and off per phase so both busy and gappy
  // stretches occur
  bit          idle_in;
  bit          idle_out;
  int          cycles;
  chip_tracker sb;

  ook_manchester_frame_serializer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard: a hung handshake ends the run here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic frame_item_t mk_item(logic [7:0] payload, logic valid,
                                          logic [7:0] seq, logic first, logic last);
    frame_item_t it;
    it.payload = payload;
    it.valid   = valid;
    it.seq     = seq;
    it.first   = first;
    it.last    = last;
    return it;
  endfunction

  // optional gap, then hold the item until in_tready is seen at an edge.
  // valid is only lowered when a gap follows, so back-to-back items keep it high
  task automatic send_item(frame_item_t it);
    int gap;
    gap = idle_in ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.seq, it.payload};
    in_tuser  <= {it.first, it.valid};
    in_tlast  <= it.last;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(it);
  endtask

  // one register write, taken at the next rising edge
  task automatic write_reg(logic [1:0] addr, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(addr, data);
  endtask

  // let every owed chip arrive, give a chip-less item time to finish, then
  // write both registers and one unused index
  task automatic reconfigure(logic [15:0] pattern, logic [15:0] len_word);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_HEADER_LENGTH, len_word);
    write_reg(REG_HEADER_PATTERN, pattern);
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // chip receiver: draws a stall before each chip, then checks the chip that
  // is taken at the first edge with tready high
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_out ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      sb.check_chip(out_tdata, out_tlast);
    end
  end

  initial begin
    int          counted;
    int          nframe;
    logic [15:0] len_word;
    frame_item_t it;

    sb        = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_HEADER_PATTERN;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    idle_in   = 1'b1;
    idle_out  = 1'b1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // reset config: no header chips, a frame still carries its sequence byte
    send_item(mk_item(8'h00, 1'b1, 8'hff, 1'b1, 1'b1));
    // empty transaction, no chips at all
    send_item(mk_item(8'hff, 1'b0, 8'hff, 1'b0, 1'b0));
    send_item(mk_item(8'hff, 1'b1, 8'h00, 1'b0, 1'b0));
    send_item(mk_item(8'ha5, 1'b1, 8'h5a, 1'b0, 1'b0));
    // stop chips alone
    send_item(mk_item(8'h00, 1'b0, 8'h00, 1'b0, 1'b1));
    // first items with an empty header: sequence only, then sequence and stop
    send_item(mk_item(8'h00, 1'b0, 8'h00, 1'b1, 1'b0));
    send_item(mk_item(8'h3c, 1'b0, 8'hc3, 1'b1, 1'b1));

    // full header of all ones, no stalls on either side
    idle_in  = 1'b0;
    idle_out = 1'b0;
    reconfigure(16'hffff, 16'h0010);
    send_item(mk_item(8'h5a, 1'b1, 8'h3c, 1'b1, 1'b1));
    send_item(mk_item(8'h00, 1'b0, 8'h80, 1'b1, 1'b0));
    send_item(mk_item(8'h01, 1'b1, 8'h00, 1'b0, 1'b1));

    // length word 0xfff1 keeps 17 in the register: capped to the full store
    idle_in  = 1'b1;
    idle_out = 1'b1;
    reconfigure(16'h8001, 16'hfff1);
    send_item(mk_item(8'h7e, 1'b1, 8'h81, 1'b1, 1'b0));
    send_item(mk_item(8'hff, 1'b1, 8'hff, 1'b1, 1'b1));

    // largest length the register holds, zero pattern
    reconfigure(16'h0000, 16'h001f);
    send_item(mk_item(8'h0f, 1'b1, 8'hf0, 1'b1, 1'b1));

    // single header chip, then four items: two first items, a middle one and a last one
    reconfigure(16'hfffe, 16'h0001);
    send_item(mk_item(8'h55, 1'b1, 8'haa, 1'b1, 1'b0));
    send_item(mk_item(8'h01, 1'b0, 8'h00, 1'b1, 1'b0));
    send_item(mk_item(8'haa, 1'b1, 8'h55, 1'b0, 1'b0));
    send_item(mk_item(8'h80, 1'b1, 8'h01, 1'b0, 1'b1));

    // --- random part: mostly whole frames, some loose items ---
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_in  = (ph % 4) != 1;
      idle_out = (ph % 4) != 2;
      case ($urandom_range(0, 4))
        0:       len_word = 16'h0000;
        1:       len_word = 16'h0010;
        2:       len_word = 16'($urandom_range(17, 31));
        3:       len_word = 16'h0001;
        default: len_word = 16'($urandom_range(0, 16));
      endcase
      // junk above the five used bits is dropped by the register
      len_word[15:5] = 11'($urandom);
      reconfigure(16'($urandom), len_word);

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) begin
          // loose transaction with random flags, possibly empty
          it = mk_item(8'($urandom), 1'($urandom), 8'($urandom),
                       1'($urandom), 1'($urandom));
          send_item(it);
          if (it.first || it.valid || it.last) counted++;
        end else begin
          // well-formed frame: first ... last, a single item is both
          nframe = $urandom_range(1, 6);
          for (int k = 0; k < nframe; k++) begin
            it = mk_item(8'($urandom), 1'b1, 8'($urandom), k == 0, k == nframe - 1);
            if ($urandom_range(0, 7) == 0) it.valid = 1'b0;
            send_item(it);
          end
          counted += nframe;
        end
      end
    end

    // drain: all chips in, then a settle window for stray output
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== ook_manchester_frame_serializer_top.f =====
src/ookms_pkg.sv
src/ook_manchester_frame_serializer_top.sv
tb/ook_manchester_frame_serializer_top_tb.sv
